FILE: src/sc2a_pkg.sv
// Shared types, scancode constants and keymap tables for the scancode-to-ASCII FIFO core.
// Has no dependencies; every other file in src imports it.
package sc2a_pkg;

    localparam int FIFO_DEPTH_DEF = 128;

    localparam logic OP_SCANCODE = 1'b0;
    localparam logic OP_READ     = 1'b1;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_EXTRA_KEY    = 8'h56;
    localparam logic [7:0] KEYMAP_LEN      = 8'd58;

    typedef struct packed {
        logic       operation;
        logic [7:0] scancode;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_char;
        logic       char_valid;
        logic       fifo_nonempty;
    } out_item_t;

    // decoder to FIFO: a character to push
    typedef struct packed {
        logic       push;
        logic [7:0] ch;
    } decode_t;

    // FIFO to top level: outcome of the current item
    typedef struct packed {
        logic pop_ok;
        logic nonempty;
    } fifo_stat_t;

    function automatic logic [7:0] keymap_plain(input logic [5:0] idx);
        logic [7:0] ch;
        case (idx)
            6'd1:  ch = 8'd27;
            6'd2:  ch = "1";
            6'd3:  ch = "2";
            6'd4:  ch = "3";
            6'd5:  ch = "4";
            6'd6:  ch = "5";
            6'd7:  ch = "6";
            6'd8:  ch = "7";
            6'd9:  ch = "8";
            6'd10: ch = "9";
            6'd11: ch = "0";
            6'd12: ch = "-";
            6'd13: ch = "=";
            6'd14: ch = 8'd8;
            6'd15: ch = 8'd9;
            6'd16: ch = "q";
            6'd17: ch = "w";
            6'd18: ch = "e";
            6'd19: ch = "r";
            6'd20: ch = "t";
            6'd21: ch = "y";
            6'd22: ch = "u";
            6'd23: ch = "i";
            6'd24: ch = "o";
            6'd25: ch = "p";
            6'd26: ch = "[";
            6'd27: ch = "]";
            6'd28: ch = 8'd10;
            6'd30: ch = "a";
            6'd31: ch = "s";
            6'd32: ch = "d";
            6'd33: ch = "f";
            6'd34: ch = "g";
            6'd35: ch = "h";
            6'd36: ch = "j";
            6'd37: ch = "k";
            6'd38: ch = "l";
            6'd39: ch = ";";
            6'd40: ch = 8'h27;
            6'd41: ch = 8'h60;
            6'd43: ch = 8'h5C;
            6'd44: ch = "z";
            6'd45: ch = "x";
            6'd46: ch = "c";
            6'd47: ch = "v";
            6'd48: ch = "b";
            6'd49: ch = "n";
            6'd50: ch = "m";
            6'd51: ch = ",";
            6'd52: ch = ".";
            6'd53: ch = "/";
            6'd55: ch = "*";
            6'd57: ch = " ";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] keymap_shifted(input logic [5:0] idx);
        logic [7:0] ch;
        case (idx)
            6'd1:  ch = 8'd27;
            6'd2:  ch = "!";
            6'd3:  ch = "@";
            6'd4:  ch = "#";
            6'd5:  ch = "$";
            6'd6:  ch = "%";
            6'd7:  ch = "^";
            6'd8:  ch = "&";
            6'd9:  ch = "*";
            6'd10: ch = "(";
            6'd11: ch = ")";
            6'd12: ch = "_";
            6'd13: ch = "+";
            6'd14: ch = 8'd8;
            6'd15: ch = 8'd9;
            6'd16: ch = "Q";
            6'd17: ch = "W";
            6'd18: ch = "E";
            6'd19: ch = "R";
            6'd20: ch = "T";
            6'd21: ch = "Y";
            6'd22: ch = "U";
            6'd23: ch = "I";
            6'd24: ch = "O";
            6'd25: ch = "P";
            6'd26: ch = "{";
            6'd27: ch = "}";
            6'd28: ch = 8'd10;
            6'd30: ch = "A";
            6'd31: ch = "S";
            6'd32: ch = "D";
            6'd33: ch = "F";
            6'd34: ch = "G";
            6'd35: ch = "H";
            6'd36: ch = "J";
            6'd37: ch = "K";
            6'd38: ch = "L";
            6'd39: ch = ":";
            6'd40: ch = 8'h22;
            6'd41: ch = "~";
            6'd43: ch = "|";
            6'd44: ch = "Z";
            6'd45: ch = "X";
            6'd46: ch = "C";
            6'd47: ch = "V";
            6'd48: ch = "B";
            6'd49: ch = "N";
            6'd50: ch = "M";
            6'd51: ch = "<";
            6'd52: ch = ">";
            6'd53: ch = "?";
            6'd55: ch = "*";
            6'd57: ch = " ";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

FILE: src/sc2a_decode.sv
// Scancode decoder: tracks the shift key and maps make codes to ASCII characters.
// Depends on sc2a_pkg for constants, keymap tables and decode_t.
module sc2a_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              code_en,
    input  logic [7:0]        code,
    output sc2a_pkg::decode_t dec
);
    import sc2a_pkg::*;

    logic       shift_held_reg;
    logic       shift_held_next;
    logic       is_make;
    logic       is_break;
    logic       in_table;
    logic [7:0] table_ch;

    assign is_make  = (code == SC_LSHIFT_MAKE) || (code == SC_RSHIFT_MAKE);
    assign is_break = (code == SC_LSHIFT_BREAK) || (code == SC_RSHIFT_BREAK);
    assign in_table = code < KEYMAP_LEN;
    assign table_ch = shift_held_reg ? keymap_shifted(code[5:0]) : keymap_plain(code[5:0]);

    always_comb begin
        shift_held_next = shift_held_reg;
        if (code_en && is_make) begin
            shift_held_next = 1'b1;
        end else if (code_en && is_break) begin
            shift_held_next = 1'b0;
        end
    end

    always_comb begin
        dec.push = 1'b0;
        dec.ch   = table_ch;
        if (code == SC_EXTRA_KEY) begin
            dec.ch   = shift_held_reg ? "|" : 8'h5C;
            dec.push = code_en;
        end else if (in_table) begin
            // zero entries (ctrl, alt, shift keys) produce nothing
            dec.push = code_en && (table_ch != 8'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_held_reg <= 1'b0;
        end else begin
            shift_held_reg <= shift_held_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (code_en && is_make) |=> shift_held_reg)
        else $error("shift make code did not set shift state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        dec.push |-> (dec.ch != 8'd0))
        else $error("decoder pushes a zero character");

endmodule

FILE: src/sc2a_fifo.sv
// Ring FIFO of characters with one slot kept free; read data is registered.
// Depends on sc2a_pkg for decode_t and fifo_stat_t.
module sc2a_fifo #(
    parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sc2a_pkg::decode_t    dec,
    input  logic                 pop_req,
    output logic [7:0]           rd_data,
    output sc2a_pkg::fifo_stat_t stat
);
    import sc2a_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;
    logic [7:0]       rd_data_reg;
    logic             empty;
    logic             full;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign head_inc = ptr_inc(head_reg);
    assign tail_inc = ptr_inc(tail_reg);
    assign empty    = head_reg == tail_reg;
    assign full     = tail_inc == head_reg;
    // drop the newest character when full
    assign do_push  = dec.push && !full;
    assign do_pop   = pop_req && !empty;

    assign head_next = do_pop ? head_inc : head_reg;
    assign tail_next = do_push ? tail_inc : tail_reg;

    assign stat.pop_ok   = do_pop;
    assign stat.nonempty = head_next != tail_next;
    assign rd_data       = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[tail_reg] <= dec.ch;
        end
        if (do_pop) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (dec.push && full) |=> $stable(tail_reg))
        else $error("push into a full FIFO moved the tail");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_req && empty) |=> $stable(head_reg))
        else $error("pop from an empty FIFO moved the head");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg <= PTR_LAST) && (tail_reg <= PTR_LAST))
        else $error("FIFO pointer beyond last slot");

endmodule

FILE: src/scancode_to_ascii_fifo_core.sv
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is not stalled; the single result register is refilled as it drains.
// The character store is one memory with one write and one registered read port.
// Reset clears the FIFO pointers, the shift state and the result valid; store is not cleared.
// Depends on sc2a_pkg, sc2a_decode and sc2a_fifo.
module scancode_to_ascii_fifo_core #(
    parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sc2a_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sc2a_pkg::out_item_t m_data
);
    import sc2a_pkg::*;

    decode_t    dec;
    fifo_stat_t stat;
    logic [7:0] rd_data;
    logic       accept;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       char_valid_reg;
    logic       nonempty_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    sc2a_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .code_en (accept && (s_data.operation == OP_SCANCODE)),
        .code    (s_data.scancode),
        .dec     (dec)
    );

    sc2a_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dec     (dec),
        .pop_req (accept && (s_data.operation == OP_READ)),
        .rd_data (rd_data),
        .stat    (stat)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            char_valid_reg <= stat.pop_ok;
            nonempty_reg   <= stat.nonempty;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_data.read_char     = char_valid_reg ? rd_data : 8'd0;
    assign m_data.char_valid    = char_valid_reg;
    assign m_data.fifo_nonempty = nonempty_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && stat.pop_ok) |=> (m_valid && m_data.char_valid))
        else $error("popped item not shown as valid character");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.operation == OP_SCANCODE)) |=> !m_data.char_valid)
        else $error("scancode item reports a character");

endmodule
